/* sv/olc_pkg.sv */
package olc_pkg;

  // window reset values, in integer pixels
  localparam int WIN_LEFT_RST  = 100;
  localparam int WIN_RIGHT_RST = 400;
  localparam int WIN_LOW_RST   = 100;
  localparam int WIN_HIGH_RST  = 400;

  // region outcode bits
  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;

  // endpoint moves allowed before giving up
  localparam logic [2:0] MAX_MOVES = 3'd4;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LEFT  = 2'd0,
    REG_RIGHT = 2'd1,
    REG_LOW   = 2'd2,
    REG_HIGH  = 2'd3
  } reg_idx_t;

  // microprogram addresses
  typedef logic [2:0] step_t;
  localparam step_t ST_IDLE     = 3'd0;
  localparam step_t ST_CHECK    = 3'd1;
  localparam step_t ST_SETUP    = 3'd2;
  localparam step_t ST_MUL      = 3'd3;
  localparam step_t ST_DIV_INIT = 3'd4;
  localparam step_t ST_DIV_STEP = 3'd5;
  localparam step_t ST_APPLY    = 3'd6;
  localparam step_t ST_EMIT     = 3'd7;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CHECK,
    OP_SETUP,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_APPLY,
    OP_EMIT
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_WAIT,
    COND_FINISH,
    COND_DIV_MORE
  } cond_t;

  // one control word
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // divider control
  typedef struct packed {
    logic init;
    logic step;
  } div_ctrl_t;

  // control store: jump to target when the condition holds, else fall through
  function automatic uword_t ucode(step_t addr);
    uword_t w;
    case (addr)
      ST_IDLE:     w = '{op: OP_NOP,      cond: COND_WAIT,     target: ST_IDLE};
      ST_CHECK:    w = '{op: OP_CHECK,    cond: COND_FINISH,   target: ST_EMIT};
      ST_SETUP:    w = '{op: OP_SETUP,    cond: COND_NEXT,     target: ST_IDLE};
      ST_MUL:      w = '{op: OP_MUL,      cond: COND_NEXT,     target: ST_IDLE};
      ST_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_NEXT,     target: ST_IDLE};
      ST_DIV_STEP: w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: ST_DIV_STEP};
      ST_APPLY:    w = '{op: OP_APPLY,    cond: COND_ALWAYS,   target: ST_CHECK};
      ST_EMIT:     w = '{op: OP_EMIT,     cond: COND_ALWAYS,   target: ST_IDLE};
      default:     w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* sv/olc_divider.sv */
module olc_divider #(
  parameter int W = 18
) (
  input  logic                clk,
  input  logic                rst,
  input  olc_pkg::div_ctrl_t  ctrl,
  input  logic [2*W-1:0]      dividend,
  input  logic [W-1:0]        divisor,
  output logic [W-1:0]        quotient,
  output logic                more
);
  import olc_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  lo;
  logic [W-1:0]  quo;
  logic [CW-1:0] count;

  logic [W:0]    sh_a, sub_a, sh_b, sub_b;
  logic          ge_a, ge_b, two;
  logic [W-1:0]  rem_a, rem_b;
  logic [W-1:0]  rem_next, lo_next, quo_next;
  logic [CW-1:0] count_next;

  // two restoring steps per cycle, the second only while two bits remain
  always_comb begin
    sh_a  = {rem, lo[W-1]};
    sub_a = sh_a - {1'b0, divisor};
    ge_a  = sh_a >= {1'b0, divisor};
    rem_a = ge_a ? sub_a[W-1:0] : sh_a[W-1:0];
    sh_b  = {rem_a, lo[W-2]};
    sub_b = sh_b - {1'b0, divisor};
    ge_b  = sh_b >= {1'b0, divisor};
    rem_b = ge_b ? sub_b[W-1:0] : sh_b[W-1:0];
    two   = count >= CW'(2);
    if (two) begin
      rem_next   = rem_b;
      lo_next    = {lo[W-3:0], 2'b00};
      quo_next   = {quo[W-3:0], ge_a, ge_b};
      count_next = count - CW'(2);
    end else begin
      rem_next   = rem_a;
      lo_next    = {lo[W-2:0], 1'b0};
      quo_next   = {quo[W-2:0], ge_a};
      count_next = count - CW'(1);
    end
  end

  // bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.init) begin
      count <= CW'(W);
    end else if (ctrl.step) begin
      count <= count_next;
    end
  end

  // the quotient fits W bits, so the high half seeds the remainder
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      rem <= dividend[2*W-1:W];
      lo  <= dividend[W-1:0];
      quo <= '0;
    end else if (ctrl.step) begin
      rem <= rem_next;
      lo  <= lo_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;
  assign more     = count > CW'(2);

endmodule

/* sv/outcode_line_clipper.sv */
// Clips one segment against the window in the four window registers with
// region outcodes; points on an edge are inside. Pulse start while busy is
// low; busy rises the next cycle and the result appears on done for exactly
// one cycle, with zero coordinates when accepted is low. The time a segment
// keeps the block busy grows with n, the number of endpoint moves (0 to 4);
// the serial divider, which makes two quotient bits per cycle, runs under a
// microcoded sequencer. A new segment may start in the cycle that shows done.
// Window writes are taken at any time but belong to idle periods. The
// receiver has no way to stall done.
module outcode_line_clipper #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [COORD_BITS-1:0]           start_x,
  input  logic [COORD_BITS-1:0]           start_y,
  input  logic [COORD_BITS-1:0]           end_x,
  input  logic [COORD_BITS-1:0]           end_y,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  olc_pkg::reg_idx_t               cfg_index,
  input  logic [COORD_BITS-1:0]           cfg_data,
  output logic                            done,
  output logic                            accepted,
  output logic [COORD_BITS+FRAC_BITS-1:0] clip_start_x,
  output logic [COORD_BITS+FRAC_BITS-1:0] clip_start_y,
  output logic [COORD_BITS+FRAC_BITS-1:0] clip_end_x,
  output logic [COORD_BITS+FRAC_BITS-1:0] clip_end_y
);
  import olc_pkg::*;

  localparam int W = COORD_BITS + FRAC_BITS;

  // window registers
  logic [COORD_BITS-1:0] win_left, win_right, win_low, win_high;
  logic [W-1:0]          left_f, right_f, low_f, high_f;

  // sequencer
  step_t  step, step_next;
  uword_t uw;
  logic   cond_true;
  logic   accept;

  // datapath registers
  logic [W-1:0]   x1, y1, x2, y2;
  logic [2:0]     moves;
  logic           ok;
  logic [W-1:0]   edge_val, base;
  logic           sel_first, axis_y, neg;
  logic [W-1:0]   md, mn, mq;
  logic [2*W-1:0] product;

  // combinational datapath
  logic [3:0]   c1, c2, co;
  logic         both_zero, finish;
  logic [W-1:0] e_s, base_s;
  logic [W:0]   dd_s, dn_s, dq_s;
  logic         ay_s;
  logic [W-1:0] quot;
  logic         div_more;
  logic [W-1:0] moved;
  div_ctrl_t    div_ctrl;

  function automatic logic [3:0] outcode(logic [W-1:0] x, logic [W-1:0] y,
                                         logic [W-1:0] l, logic [W-1:0] r,
                                         logic [W-1:0] b, logic [W-1:0] t);
    logic [3:0] c;
    c = '0;
    if (x < l) begin
      c = c | CODE_LEFT;
    end else if (x > r) begin
      c = c | CODE_RIGHT;
    end
    if (y < b) begin
      c = c | CODE_BOTTOM;
    end else if (y > t) begin
      c = c | CODE_TOP;
    end
    return c;
  endfunction

  function automatic logic [W:0] diff(logic [W-1:0] a, logic [W-1:0] b);
    return {1'b0, a} - {1'b0, b};
  endfunction

  function automatic logic [W-1:0] mag(logic [W:0] v);
    logic [W:0] m;
    m = v[W] ? (~v + 1'b1) : v;
    return m[W-1:0];
  endfunction

  // window edges in fixed point
  assign left_f  = W'(win_left) << FRAC_BITS;
  assign right_f = W'(win_right) << FRAC_BITS;
  assign low_f   = W'(win_low) << FRAC_BITS;
  assign high_f  = W'(win_high) << FRAC_BITS;

  // handshake
  assign busy      = step != ST_IDLE;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // outcodes and decisions
  assign c1        = outcode(x1, y1, left_f, right_f, low_f, high_f);
  assign c2        = outcode(x2, y2, left_f, right_f, low_f, high_f);
  assign both_zero = (c1 == 4'd0) && (c2 == 4'd0);
  assign finish    = both_zero || ((c1 & c2) != 4'd0) || (moves >= MAX_MOVES);
  assign co        = (c1 != 4'd0) ? c1 : c2;

  // edge selection and interpolation operands
  always_comb begin
    if ((co & (CODE_TOP | CODE_BOTTOM)) != 4'd0) begin
      e_s    = ((co & CODE_TOP) != 4'd0) ? high_f : low_f;
      base_s = x1;
      dd_s   = diff(x2, x1);
      dn_s   = diff(e_s, y1);
      dq_s   = diff(y2, y1);
      ay_s   = 1'b1;
    end else begin
      e_s    = ((co & CODE_RIGHT) != 4'd0) ? right_f : left_f;
      base_s = y1;
      dd_s   = diff(y2, y1);
      dn_s   = diff(e_s, x1);
      dq_s   = diff(x2, x1);
      ay_s   = 1'b0;
    end
  end

  // moved coordinate, base + d*num/den truncated toward zero
  always_comb begin
    if (mq == '0) begin
      moved = base;
    end else if (neg) begin
      moved = base - quot;
    end else begin
      moved = base + quot;
    end
  end

  // control word and next step
  assign uw = ucode(step);

  always_comb begin
    case (uw.cond)
      COND_NEXT:     cond_true = 1'b0;
      COND_ALWAYS:   cond_true = 1'b1;
      COND_WAIT:     cond_true = !start;
      COND_FINISH:   cond_true = finish;
      COND_DIV_MORE: cond_true = div_more;
      default:       cond_true = 1'b1;
    endcase
    step_next = cond_true ? uw.target : step_t'(step + 1'b1);
  end

  assign div_ctrl.init = uw.op == OP_DIV_INIT;
  assign div_ctrl.step = uw.op == OP_DIV_STEP;

  olc_divider #(
    .W(W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (product),
    .divisor  (mq),
    .quotient (quot),
    .more     (div_more)
  );

  // control state and window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_IDLE;
      done      <= 1'b0;
      win_left  <= COORD_BITS'(WIN_LEFT_RST);
      win_right <= COORD_BITS'(WIN_RIGHT_RST);
      win_low   <= COORD_BITS'(WIN_LOW_RST);
      win_high  <= COORD_BITS'(WIN_HIGH_RST);
    end else begin
      step <= step_next;
      done <= uw.op == OP_EMIT;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEFT:  win_left  <= cfg_data;
          REG_RIGHT: win_right <= cfg_data;
          REG_LOW:   win_low   <= cfg_data;
          REG_HIGH:  win_high  <= cfg_data;
          default:   ;
        endcase
      end
    end
  end

  // datapath driven by the control word
  always_ff @(posedge clk) begin
    if (accept) begin
      x1    <= W'(start_x) << FRAC_BITS;
      y1    <= W'(start_y) << FRAC_BITS;
      x2    <= W'(end_x) << FRAC_BITS;
      y2    <= W'(end_y) << FRAC_BITS;
      moves <= '0;
    end
    case (uw.op)
      OP_CHECK: begin
        ok <= both_zero;
      end
      OP_SETUP: begin
        edge_val  <= e_s;
        base      <= base_s;
        axis_y    <= ay_s;
        sel_first <= c1 != 4'd0;
        md        <= mag(dd_s);
        mn        <= mag(dn_s);
        mq        <= mag(dq_s);
        neg       <= dd_s[W] ^ dn_s[W] ^ dq_s[W];
      end
      OP_MUL: begin
        product <= (2*W)'(md) * (2*W)'(mn);
      end
      OP_APPLY: begin
        if (sel_first) begin
          x1 <= axis_y ? moved : edge_val;
          y1 <= axis_y ? edge_val : moved;
        end else begin
          x2 <= axis_y ? moved : edge_val;
          y2 <= axis_y ? edge_val : moved;
        end
        moves <= moves + 3'd1;
      end
      OP_EMIT: begin
        accepted     <= ok;
        clip_start_x <= ok ? x1 : '0;
        clip_start_y <= ok ? y1 : '0;
        clip_end_x   <= ok ? x2 : '0;
        clip_end_y   <= ok ? y2 : '0;
      end
      default: ;
    endcase
  end

endmodule

/* sv/olc_checker.sv */
module olc_checker #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 8
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic [COORD_BITS-1:0]           start_x,
  input logic [COORD_BITS-1:0]           start_y,
  input logic [COORD_BITS-1:0]           end_x,
  input logic [COORD_BITS-1:0]           end_y,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input olc_pkg::reg_idx_t               cfg_index,
  input logic [COORD_BITS-1:0]           cfg_data,
  input logic                            done,
  input logic                            accepted,
  input logic [COORD_BITS+FRAC_BITS-1:0] clip_start_x,
  input logic [COORD_BITS+FRAC_BITS-1:0] clip_start_y,
  input logic [COORD_BITS+FRAC_BITS-1:0] clip_end_x,
  input logic [COORD_BITS+FRAC_BITS-1:0] clip_end_y
);
  import olc_pkg::*;

  // an accepted segment keeps the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after start");

  // a result comes only from a busy block and frees it
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("done without preceding work");

  // result strobe lasts one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // rejected segments report zero coordinates
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && !accepted |-> clip_start_x == '0 && clip_start_y == '0 &&
                          clip_end_x == '0 && clip_end_y == '0)
    else $error("rejected segment with nonzero coordinates");

endmodule

bind outcode_line_clipper olc_checker #(
  .COORD_BITS(COORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_olc_checker (.*);
